### design/grid_k_nearest_valid_vertex_core_macros.svh
// Assertion helpers for the grid nearest-vertex search block.
`ifndef GRID_K_NEAREST_VALID_VERTEX_CORE_MACROS_SVH
`define GRID_K_NEAREST_VALID_VERTEX_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define GKNV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gknv same-cycle check failed");
// Next-cycle implication, held off during reset.
`define GKNV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gknv next-cycle check failed");
`else
`define GKNV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GKNV_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

### design/gknv_pkg.sv
package gknv_pkg;

    // Sizes of the stores and of the fixed fields.
    localparam int MAX_VERTICES = 4096;
    localparam int MAX_K        = 16;
    localparam int VTX_W        = 12;
    localparam int K_W          = 5;
    localparam int LIST_IDX_W   = 4;
    localparam int D2_W         = 26;
    localparam int DIST_W       = 21;
    localparam int DIM_W        = 13;
    localparam int GS_W         = 7;
    localparam int COORD_W      = 15;
    localparam int CFG_IDX_W    = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Register reset values.
    localparam logic [GS_W-1:0]  GS_RESET     = 7'd15;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // Commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_NONE  = 2'd2;

    // Setup divisions, in the order the sequencer runs them.
    localparam logic [2:0] DIV_COLS = 3'd0;
    localparam logic [2:0] DIV_ROWS = 3'd1;
    localparam logic [2:0] DIV_CX   = 3'd2;
    localparam logic [2:0] DIV_CY   = 3'd3;
    localparam logic [2:0] DIV_CAP  = 3'd4;

    typedef struct packed {
        logic             cmd;
        logic [11:0]      vertex_index;
        logic             valid_flag;
        logic [11:0]      query_x;
        logic [11:0]      query_y;
        logic [K_W-1:0]   k_wanted;
    } req_t;

    typedef struct packed {
        logic [VTX_W-1:0]  found_index;
        logic [DIST_W-1:0] distance;
        logic [1:0]        status;
        logic              last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RING,
        ST_ADDR,
        ST_SQ,
        ST_INS,
        ST_RING_END,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_EMIT
    } state_t;

endpackage

### design/grid_k_nearest_valid_vertex_core.sv
// Nearest valid grid vertex search.
// Request channel (req_valid, req_stall, req_data): a beat is taken when
// req_valid is high and req_stall is low. A write beat sets one vertex mark
// and gives no response. A query beat starts a search.
// Response channel (rsp_valid, rsp_stall, rsp_data): one beat per vertex
// found (at most k), nearest first, last set on the final beat of a query.
// A query runs five setup divisions in one shared serial divider, then
// walks the ring cells inside the grid through the ADDR, SQ and INS states
// per cell, with a RING state per ring side and a RING_END state per ring,
// and finally runs the shared square-root unit for each result and loads
// its beat; with none found it loads one beat with status none. One query
// is in flight at a time. After reset the mark memory is cleared one entry
// per cycle, all 4096 entries, with req_stall high; configuration writes
// are taken during that time. A stalled response beat holds in the output
// register; the block may already take the next request while it waits,
// and the next query waits only when its first beat is ready to load.
module grid_k_nearest_valid_vertex_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  gknv_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output gknv_pkg::rsp_t                    rsp_data,
    input  logic                              cfg_we,
    input  logic [gknv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gknv_pkg::DIM_W-1:0]        cfg_data
);

    localparam int VW  = gknv_pkg::VTX_W;
    localparam int CW  = gknv_pkg::COORD_W;
    localparam int DW  = gknv_pkg::DIM_W;
    localparam int NK  = gknv_pkg::MAX_K;
    localparam int LW  = gknv_pkg::LIST_IDX_W;
    localparam int D2W = gknv_pkg::D2_W;

    gknv_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [gknv_pkg::GS_W-1:0] gs_cfg_reg;
    logic [DW-1:0]             width_cfg_reg;
    logic [DW-1:0]             height_cfg_reg;

    // Query setup.
    logic [VW-1:0]             clr_cnt_reg;
    logic [11:0]               qx_reg, qy_reg;
    logic [gknv_pkg::K_W-1:0]  k_reg;
    logic [gknv_pkg::GS_W-1:0] gs_reg;
    logic [DW-1:0]             wc_reg, hc_reg;
    logic [2:0]                div_sel_reg;
    logic [DW-1:0]             ncols_reg, nrows_reg;
    logic [11:0]               cx_reg, cy_reg;

    // Ring walk.
    logic [11:0]               rad_reg;
    logic [1:0]                side_reg;
    logic signed [CW-1:0]      cur_reg, end_reg, fixed_reg;
    logic                      dir_reg, row_reg;
    logic [VW-1:0]             idx_reg;
    logic                      idx_ok_reg;
    logic signed [13:0]        dx_reg, dy_reg;
    logic [23:0]               sqx_reg, sqy_reg;
    logic                      mark_rd_reg;
    logic                      marks_mem [gknv_pkg::MAX_VERTICES];

    // Sorted candidate list.
    logic [VW-1:0]             list_i_reg [NK];
    logic [D2W-1:0]            list_d_reg [NK];
    logic [LW:0]               list_len_reg;
    logic [DW-1:0]             found_reg;

    // Emission.
    logic [LW-1:0]             oi_reg;
    logic                      none_reg;
    logic                      out_valid_reg;
    gknv_pkg::rsp_t            out_data_reg;

    // Strobes from the sequencer.
    logic req_take, div_start, sqrt_start, rsp_free, rsp_load;

    // Shared units.
    logic          div_done, sqrt_done;
    logic [DW-1:0] div_dividend, div_divisor, div_q;
    logic [gknv_pkg::DIST_W-1:0] sqrt_root;

    gknv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    gknv_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (list_d_reg[oi_reg]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Divider operands for each setup step.
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = DW'(gs_reg);
        unique case (div_sel_reg)
            gknv_pkg::DIV_COLS: div_dividend = wc_reg - 1'b1;
            gknv_pkg::DIV_ROWS: div_dividend = hc_reg - 1'b1;
            gknv_pkg::DIV_CX:   div_dividend = DW'(qx_reg);
            gknv_pkg::DIV_CY:   div_dividend = DW'(qy_reg);
            gknv_pkg::DIV_CAP:
            begin
                div_dividend = DW'(gknv_pkg::MAX_VERTICES - 1) + ncols_reg;
                div_divisor  = ncols_reg;
            end
            default: div_dividend = '0;
        endcase
    end

    // Ring side geometry, clipped to the grid.
    logic signed [CW-1:0] cx_s, cy_s, rad_s, side_a, side_b, side_fx;
    logic signed [CW-1:0] lim_s, flim_s, clip_a, clip_b;
    logic                 side_row, side_desc, side_go;

    always_comb
    begin
        cx_s  = CW'(cx_reg);
        cy_s  = CW'(cy_reg);
        rad_s = CW'(rad_reg);
        side_row = 1'b1;
        side_fx  = cy_s - rad_s;
        side_a   = cx_s - rad_s;
        side_b   = cx_s + rad_s;
        unique case (side_reg)
            2'd0:
            begin
                side_row = 1'b1;
                side_fx  = cy_s - rad_s;
                side_a   = cx_s - rad_s;
                side_b   = cx_s + rad_s;
            end
            2'd1:
            begin
                side_row = 1'b0;
                side_fx  = cx_s + rad_s + 2'sd1;
                side_a   = cy_s - rad_s;
                side_b   = cy_s + rad_s;
            end
            2'd2:
            begin
                side_row = 1'b1;
                side_fx  = cy_s + rad_s + 2'sd1;
                side_a   = cx_s + rad_s + 2'sd1;
                side_b   = cx_s - rad_s + 2'sd1;
            end
            default:
            begin
                side_row = 1'b0;
                side_fx  = cx_s - rad_s;
                side_a   = cy_s + rad_s + 2'sd1;
                side_b   = cy_s - rad_s + 2'sd1;
            end
        endcase
        lim_s     = side_row ? CW'(ncols_reg) : CW'(nrows_reg);
        flim_s    = side_row ? CW'(nrows_reg) : CW'(ncols_reg);
        side_desc = (side_a > side_b);
        if (!side_desc)
        begin
            clip_a = (side_a < 0) ? '0 : side_a;
            clip_b = (side_b > lim_s - 2'sd1) ? lim_s - 2'sd1 : side_b;
        end
        else
        begin
            clip_a = (side_a > lim_s - 2'sd1) ? lim_s - 2'sd1 : side_a;
            clip_b = (side_b < 0) ? '0 : side_b;
        end
        side_go = (side_fx >= 0) && (side_fx < flim_s) &&
                  (side_desc ? (clip_a >= clip_b) : (clip_a <= clip_b));
    end

    // Cell address and offsets from the query point.
    logic [11:0]          cell_c, cell_r;
    logic [24:0]          idx_full;
    logic [18:0]          px, py;
    logic signed [19:0]   dx_full, dy_full;
    logic signed [27:0]   sqx_full, sqy_full;

    always_comb
    begin
        cell_c   = row_reg ? cur_reg[11:0] : fixed_reg[11:0];
        cell_r   = row_reg ? fixed_reg[11:0] : cur_reg[11:0];
        idx_full = (cell_r * ncols_reg) + 25'(cell_c);
        px       = cell_c * gs_reg;
        py       = cell_r * gs_reg;
        dx_full  = $signed({1'b0, px}) - $signed({8'd0, qx_reg});
        dy_full  = $signed({1'b0, py}) - $signed({8'd0, qy_reg});
        sqx_full = dx_reg * dx_reg;
        sqy_full = dy_reg * dy_reg;
    end

    // Stable insertion into the sorted list.
    logic [D2W-1:0] d2_new;
    logic [NK-1:0]  le;
    logic           ins_hit;

    always_comb
    begin
        d2_new = D2W'(sqx_reg) + D2W'(sqy_reg);
        for (int i = 0; i < NK; i++)
        begin
            le[i] = ((LW+1)'(i) < list_len_reg) && (list_d_reg[i] <= d2_new);
        end
        ins_hit = idx_ok_reg && mark_rd_reg;
    end

    // Ring stop test and emission values.
    logic          ring_stop;
    logic [LW:0]   emit_n;
    logic          emit_last;
    logic [1:0]    emit_status;

    always_comb
    begin
        ring_stop = (found_reg >= DW'(k_reg)) ||
                    ((cx_s - rad_s <= 0) && (cx_s + rad_s + 2'sd1 >= CW'(ncols_reg) - 2'sd1) &&
                     (cy_s - rad_s <= 0) && (cy_s + rad_s + 2'sd1 >= CW'(nrows_reg) - 2'sd1));
        emit_n      = (list_len_reg < k_reg) ? list_len_reg : k_reg;
        emit_status = (list_len_reg < k_reg) ? gknv_pkg::STATUS_SHORT : gknv_pkg::STATUS_OK;
        emit_last   = ({1'b0, oi_reg} == emit_n - 1'b1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gknv_pkg::ST_CLEAR:
                if (clr_cnt_reg == '1) state_next = gknv_pkg::ST_IDLE;
            gknv_pkg::ST_IDLE:
                if (req_valid && (req_data.cmd == gknv_pkg::CMD_QUERY))
                    state_next = gknv_pkg::ST_DIV_GO;
            gknv_pkg::ST_DIV_GO:
                state_next = gknv_pkg::ST_DIV_WAIT;
            gknv_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = (div_sel_reg == gknv_pkg::DIV_CAP) ?
                                 gknv_pkg::ST_RING : gknv_pkg::ST_DIV_GO;
            gknv_pkg::ST_RING:
                if (side_go) state_next = gknv_pkg::ST_ADDR;
                else if (side_reg == 2'd3) state_next = gknv_pkg::ST_RING_END;
            gknv_pkg::ST_ADDR:
                state_next = gknv_pkg::ST_SQ;
            gknv_pkg::ST_SQ:
                state_next = gknv_pkg::ST_INS;
            gknv_pkg::ST_INS:
                if (cur_reg != end_reg) state_next = gknv_pkg::ST_ADDR;
                else if (side_reg == 2'd3) state_next = gknv_pkg::ST_RING_END;
                else state_next = gknv_pkg::ST_RING;
            gknv_pkg::ST_RING_END:
                if (ring_stop)
                    state_next = (list_len_reg == '0) ? gknv_pkg::ST_EMIT :
                                 gknv_pkg::ST_SQRT_GO;
                else
                    state_next = gknv_pkg::ST_RING;
            gknv_pkg::ST_SQRT_GO:
                state_next = gknv_pkg::ST_SQRT_WAIT;
            gknv_pkg::ST_SQRT_WAIT:
                if (sqrt_done) state_next = gknv_pkg::ST_EMIT;
            gknv_pkg::ST_EMIT:
                if (rsp_free)
                    state_next = (none_reg || emit_last) ? gknv_pkg::ST_IDLE :
                                 gknv_pkg::ST_SQRT_GO;
            default:
                state_next = gknv_pkg::ST_IDLE;
        endcase
    end

    // Sequencer strobes.
    always_comb
    begin
        req_stall  = (state_reg != gknv_pkg::ST_IDLE);
        req_take   = req_valid && !req_stall;
        div_start  = (state_reg == gknv_pkg::ST_DIV_GO);
        sqrt_start = (state_reg == gknv_pkg::ST_SQRT_GO);
        rsp_free   = !out_valid_reg || !rsp_stall;
        rsp_load   = (state_reg == gknv_pkg::ST_EMIT) && rsp_free;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gknv_pkg::ST_CLEAR;
            gs_cfg_reg     <= gknv_pkg::GS_RESET;
            width_cfg_reg  <= gknv_pkg::WIDTH_RESET;
            height_cfg_reg <= gknv_pkg::HEIGHT_RESET;
            clr_cnt_reg    <= '0;
            div_sel_reg    <= '0;
            rad_reg        <= '0;
            side_reg       <= '0;
            list_len_reg   <= '0;
            found_reg      <= '0;
            oi_reg         <= '0;
            none_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    gknv_pkg::REG_GRID_SPACING: gs_cfg_reg <= cfg_data[gknv_pkg::GS_W-1:0];
                    gknv_pkg::REG_IMAGE_WIDTH:  width_cfg_reg <= cfg_data;
                    gknv_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == gknv_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (req_take)
            begin
                div_sel_reg  <= gknv_pkg::DIV_COLS;
                rad_reg      <= '0;
                side_reg     <= '0;
                list_len_reg <= '0;
                found_reg    <= '0;
                oi_reg       <= '0;
            end

            if ((state_reg == gknv_pkg::ST_DIV_WAIT) && div_done)
                div_sel_reg <= div_sel_reg + 1'b1;

            if ((state_reg == gknv_pkg::ST_RING) && !side_go && (side_reg != 2'd3))
                side_reg <= side_reg + 1'b1;

            if ((state_reg == gknv_pkg::ST_INS) && (cur_reg == end_reg) &&
                (side_reg != 2'd3))
                side_reg <= side_reg + 1'b1;

            if ((state_reg == gknv_pkg::ST_INS) && ins_hit)
            begin
                found_reg <= found_reg + 1'b1;
                if (!le[NK-1] && (list_len_reg != (LW+1)'(NK)))
                    list_len_reg <= list_len_reg + 1'b1;
            end

            if (state_reg == gknv_pkg::ST_RING_END)
            begin
                none_reg <= (list_len_reg == '0);
                if (!ring_stop)
                begin
                    rad_reg  <= rad_reg + 1'b1;
                    side_reg <= '0;
                end
            end

            if (rsp_load)
            begin
                out_valid_reg <= 1'b1;
                oi_reg        <= oi_reg + 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            qx_reg <= req_data.query_x;
            qy_reg <= req_data.query_y;
            if (req_data.k_wanted == '0)
                k_reg <= 5'd1;
            else if (req_data.k_wanted > gknv_pkg::K_W'(NK))
                k_reg <= gknv_pkg::K_W'(NK);
            else
                k_reg <= req_data.k_wanted;
            if (gs_cfg_reg < 7'd2)
                gs_reg <= 7'd2;
            else if (gs_cfg_reg > 7'd64)
                gs_reg <= 7'd64;
            else
                gs_reg <= gs_cfg_reg;
            if (width_cfg_reg == '0)
                wc_reg <= 13'd1;
            else if (width_cfg_reg > DW'(gknv_pkg::MAX_VERTICES))
                wc_reg <= DW'(gknv_pkg::MAX_VERTICES);
            else
                wc_reg <= width_cfg_reg;
            if (height_cfg_reg == '0)
                hc_reg <= 13'd1;
            else if (height_cfg_reg > DW'(gknv_pkg::MAX_VERTICES))
                hc_reg <= DW'(gknv_pkg::MAX_VERTICES);
            else
                hc_reg <= height_cfg_reg;
        end

        // Setup division results.
        if ((state_reg == gknv_pkg::ST_DIV_WAIT) && div_done)
        begin
            unique case (div_sel_reg)
                gknv_pkg::DIV_COLS: ncols_reg <= div_q + 1'b1;
                gknv_pkg::DIV_ROWS: nrows_reg <= div_q + 1'b1;
                gknv_pkg::DIV_CX:   cx_reg <= div_q[11:0];
                gknv_pkg::DIV_CY:   cy_reg <= div_q[11:0];
                gknv_pkg::DIV_CAP:
                    if (nrows_reg > div_q) nrows_reg <= div_q;
                default: ;
            endcase
        end

        // Side setup.
        if ((state_reg == gknv_pkg::ST_RING) && side_go)
        begin
            cur_reg   <= clip_a;
            end_reg   <= clip_b;
            fixed_reg <= side_fx;
            dir_reg   <= side_desc;
            row_reg   <= side_row;
        end

        // Cell visit: address, squares, insertion.
        if (state_reg == gknv_pkg::ST_ADDR)
        begin
            idx_reg    <= idx_full[VW-1:0];
            idx_ok_reg <= (idx_full < 25'(gknv_pkg::MAX_VERTICES));
            dx_reg     <= dx_full[13:0];
            dy_reg     <= dy_full[13:0];
        end

        if (state_reg == gknv_pkg::ST_SQ)
        begin
            sqx_reg <= sqx_full[23:0];
            sqy_reg <= sqy_full[23:0];
        end

        if (state_reg == gknv_pkg::ST_INS)
        begin
            if (ins_hit && !le[NK-1])
            begin
                for (int i = 0; i < NK; i++)
                begin
                    if (!le[i])
                    begin
                        if ((i == 0) || le[(i == 0) ? 0 : i - 1])
                        begin
                            list_i_reg[i] <= idx_reg;
                            list_d_reg[i] <= d2_new;
                        end
                        else
                        begin
                            list_i_reg[i] <= list_i_reg[(i == 0) ? 0 : i - 1];
                            list_d_reg[i] <= list_d_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
            end
            if (cur_reg != end_reg)
                cur_reg <= dir_reg ? cur_reg - 2'sd1 : cur_reg + 2'sd1;
        end

        // Response payload.
        if (rsp_load)
        begin
            if (none_reg)
            begin
                out_data_reg.found_index <= '0;
                out_data_reg.distance    <= '0;
                out_data_reg.status      <= gknv_pkg::STATUS_NONE;
                out_data_reg.last        <= 1'b1;
            end
            else
            begin
                out_data_reg.found_index <= list_i_reg[oi_reg];
                out_data_reg.distance    <= sqrt_root;
                out_data_reg.status      <= emit_status;
                out_data_reg.last        <= emit_last;
            end
        end
    end

    // Mark memory: clearing pass or write beats, one read for the walk.
    always_ff @(posedge clk)
    begin
        if (state_reg == gknv_pkg::ST_CLEAR)
            marks_mem[clr_cnt_reg] <= 1'b0;
        else if (req_take && (req_data.cmd == gknv_pkg::CMD_WRITE))
            marks_mem[req_data.vertex_index] <= req_data.valid_flag;
        mark_rd_reg <= marks_mem[idx_reg];
    end

    `include "grid_k_nearest_valid_vertex_core_macros.svh"

    `GKNV_ASSERT_IMP(a_list_bound, clk, rst_n, 1'b1, list_len_reg <= (LW+1)'(NK))
    `GKNV_ASSERT_IMP(a_no_rsp_in_clear, clk, rst_n, state_reg == gknv_pkg::ST_CLEAR, !out_valid_reg)
    `GKNV_ASSERT_IMP(a_emit_in_range, clk, rst_n, (state_reg == gknv_pkg::ST_EMIT) && !none_reg, {1'b0, oi_reg} < emit_n)
    `GKNV_ASSERT_NXT(a_last_goes_idle, clk, rst_n, rsp_load && (none_reg || emit_last), state_reg == gknv_pkg::ST_IDLE)

endmodule

### design/gknv_div.sv
// Restoring divider, one quotient bit per cycle.
module gknv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gknv_pkg::DIM_W-1:0]    dividend,
    input  logic [gknv_pkg::DIM_W-1:0]    divisor,
    output logic                          done,
    output logic [gknv_pkg::DIM_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(gknv_pkg::DIM_W + 1);

    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [gknv_pkg::DIM_W-1:0]  rem_reg;
    logic [gknv_pkg::DIM_W-1:0]  quo_reg;
    logic [gknv_pkg::DIM_W-1:0]  dsr_reg;
    logic [gknv_pkg::DIM_W:0]    rem_sh;
    logic                        q_bit;

    // Shift in the next dividend bit and try the subtraction.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[gknv_pkg::DIM_W-1]};
        q_bit  = (rem_sh >= {1'b0, dsr_reg});
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(gknv_pkg::DIM_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (q_bit)
            begin
                rem_reg <= gknv_pkg::DIM_W'(rem_sh - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= rem_sh[gknv_pkg::DIM_W-1:0];
            end
            quo_reg <= {quo_reg[gknv_pkg::DIM_W-2:0], q_bit};
        end
    end

endmodule

### design/gknv_sqrt.sv
// Digit-by-digit square root of (radicand << 16), one root bit per cycle.
module gknv_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gknv_pkg::D2_W-1:0]     radicand,
    output logic                          done,
    output logic [gknv_pkg::DIST_W-1:0]   root
);

    localparam int N_W   = 2 * gknv_pkg::DIST_W;
    localparam int REM_W = gknv_pkg::DIST_W + 3;
    localparam int CNT_W = $clog2(gknv_pkg::DIST_W + 1);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [N_W-1:0]                n_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [gknv_pkg::DIST_W-1:0]   root_reg;
    logic [REM_W+1:0]              rem_sh;
    logic [REM_W+1:0]              trial;
    logic                          fits;

    // Bring down the next bit pair and test root*4+1 against it.
    always_comb
    begin
        rem_sh = {rem_reg, n_reg[N_W-1 -: 2]};
        trial  = (REM_W+2)'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_reg;

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(gknv_pkg::DIST_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Remainder and root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= N_W'({radicand, 16'd0});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            n_reg <= {n_reg[N_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[gknv_pkg::DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[gknv_pkg::DIST_W-2:0], 1'b0};
            end
        end
    end

endmodule
